// ===== rtl/avgp_pkg.sv =====
// ----------------------------------------------------------------------------
// avgp_pkg: shared types and constants for the average pooling block
// Sizes, register indexes and the structs that pass between the sequencer,
// the shared divider and the line store.
// ----------------------------------------------------------------------------
package avgp_pkg;

   // frame limits
   localparam int MAX_WIDTH    = 256;
   localparam int MAX_HEIGHT   = 4096;
   localparam int MAX_CHANNELS = 64;
   localparam int MAX_POOL     = 8;
   localparam int MAX_RESULTS  = 64;

   // field and register widths
   localparam int SAMPLE_W   = 16;
   localparam int ROW_W      = 12;
   localparam int COL_W      = 8;
   localparam int CH_W       = 6;
   localparam int POOL_W     = 4;
   localparam int WID_W      = 9;
   localparam int DIM_W      = 13;
   localparam int CHN_W      = 7;
   localparam int PAD_W      = 3;
   localparam int RES_W      = 6;
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 13;

   // line store: one slot per window row, per column, per channel
   localparam int SLOT_W      = $clog2(MAX_POOL);
   localparam int ADDR_W      = SLOT_W + COL_W + CH_W;
   localparam int STORE_DEPTH = MAX_POOL * MAX_WIDTH * MAX_CHANNELS;

   // window sum and shared divider
   localparam int SUM_W  = SAMPLE_W + $clog2(MAX_POOL * MAX_POOL);
   localparam int CNT_W  = $clog2(MAX_POOL * MAX_POOL + 1);
   localparam int DVD_W  = SUM_W;
   localparam int DVS_W  = CNT_W;
   localparam int DCNT_W = $clog2(DVD_W + 1);

   // register values after reset, and the frame geometry they give
   localparam logic [POOL_W-1:0] RST_POOL   = 4'd2;
   localparam logic [POOL_W-1:0] RST_STRIDE = 4'd2;
   localparam logic [WID_W-1:0]  RST_WIDTH  = 9'd256;
   localparam logic [DIM_W-1:0]  RST_HEIGHT = 13'd256;
   localparam logic [CHN_W-1:0]  RST_CHANS  = 7'd1;
   localparam logic [WID_W-1:0]  RST_OUT_W  = 9'd128;
   localparam logic [DIM_W-1:0]  RST_OUT_H  = 13'd128;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_POOL_WIDTH    = 3'd0,
      CSR_POOL_HEIGHT   = 3'd1,
      CSR_STRIDE_WIDTH  = 3'd2,
      CSR_STRIDE_HEIGHT = 3'd3,
      CSR_IN_WIDTH      = 3'd4,
      CSR_IN_HEIGHT     = 3'd5,
      CSR_CHANNELS      = 3'd6,
      CSR_SAME_PADDING  = 3'd7
   } csr_index_type;

   typedef struct packed {
      logic             start;
      logic [DVD_W-1:0] dividend;
      logic [DVS_W-1:0] divisor;
   } div_req_type;

   typedef struct packed {
      logic             done;
      logic [DVD_W-1:0] quotient;
      logic [DVS_W-1:0] remainder;
   } div_rsp_type;

   typedef struct packed {
      logic                en;
      logic [ADDR_W-1:0]   addr;
      logic [SAMPLE_W-1:0] data;
   } store_wr_type;

endpackage

// ===== rtl/avgp_req_if.sv =====
// ----------------------------------------------------------------------------
// avgp_req_if: input sample channel
// Valid/ready channel that carries one signed Q8.8 sample per beat.
// ----------------------------------------------------------------------------
interface avgp_req_if;
   import avgp_pkg::*;

   logic                valid;
   logic                ready;
   logic [SAMPLE_W-1:0] sample;

   modport source (output valid, output sample, input ready);
   modport sink   (input valid, input sample, output ready);

endinterface

// ===== rtl/avgp_rsp_if.sv =====
// ----------------------------------------------------------------------------
// avgp_rsp_if: pooled result channel
// Valid/ready channel that carries one window average and its coordinates.
// ----------------------------------------------------------------------------
interface avgp_rsp_if;
   import avgp_pkg::*;

   logic                valid;
   logic                ready;
   logic [SAMPLE_W-1:0] average;
   logic [ROW_W-1:0]    out_row;
   logic [COL_W-1:0]    out_col;
   logic [CH_W-1:0]     channel;
   logic                last;
   logic                frame_end;

   modport source (output valid, output average, output out_row, output out_col,
                   output channel, output last, output frame_end, input ready);
   modport sink   (input valid, input average, input out_row, input out_col,
                   input channel, input last, input frame_end, output ready);

endinterface

// ===== rtl/avg_pool_2d_forward.sv =====
// ----------------------------------------------------------------------------
// avg_pool_2d_forward: streaming 2-D average pooling, padding excluded
// Samples arrive in raster order, channel fastest; each sample that closes
// pooling windows yields one result per window for its channel.
// ----------------------------------------------------------------------------
// One sample is taken at a time; ready is low until all of its results are
// delivered. Every division runs on one shared 22-bit restoring divider.
// A sample takes up to two divides for the window-end test (one per axis),
// and each result it causes adds a read of every window cell from the line
// store and a divide for the average, plus any wait on rsp ready. The
// first sample of a frame also latches the registers and derives the output
// size and padding. Register writes take effect at the start of the next
// frame. The line store needs no clearing after reset.
module avg_pool_2d_forward (
   input  logic                            clock,
   input  logic                            reset,
   avgp_req_if.sink                        req_bus,
   avgp_rsp_if.source                      rsp_bus,
   input  logic                            csr_wr_en,
   input  logic [avgp_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [avgp_pkg::CSR_DATA_W-1:0] csr_data
);
   import avgp_pkg::*;

   localparam int TOT_W = DIM_W + POOL_W + 1;
   localparam int T_W   = DIM_W + 2;
   localparam int WIN_W = 18;

   typedef enum logic [3:0] {
      S_IDLE, S_LAT_DIV, S_LAT_WAIT, S_LAT_PAD, S_RNG_DIV, S_RNG_WAIT,
      S_RNG_END, S_WIN_MUL, S_WIN_CLIP, S_SUM, S_SUM_TAIL, S_AVG_DIV,
      S_AVG_WAIT, S_OUT, S_FIN
   } state_type;

   // configuration registers
   logic [POOL_W-1:0] cfg_pw_ff, cfg_ph_ff, cfg_sw_ff, cfg_sh_ff;
   logic [WID_W-1:0]  cfg_w_ff;
   logic [DIM_W-1:0]  cfg_h_ff;
   logic [CHN_W-1:0]  cfg_c_ff;
   logic              cfg_same_ff;

   // frame geometry latched at frame start
   logic [POOL_W-1:0] pw_ff, ph_ff, sw_ff, sh_ff;
   logic [WID_W-1:0]  w_ff, outw_ff;
   logic [DIM_W-1:0]  h_ff, outh_ff;
   logic [CHN_W-1:0]  c_ff;
   logic              same_ff;
   logic [PAD_W-1:0]  padl_ff, padt_ff;

   // stream position
   logic [ROW_W-1:0] row_ff;
   logic [COL_W-1:0] col_ff;
   logic [CH_W-1:0]  chan_ff;

   // sequencer
   state_type         state_ff;
   logic              axis_ff;
   logic              empty_ff;
   logic [ROW_W-1:0]  ylo_ff, yhi_ff, oy_ff;
   logic [COL_W-1:0]  xlo_ff, xhi_ff, ox_ff;
   logic [RES_W-1:0]  res_cnt_ff;
   logic [ROW_W+POOL_W-1:0] ys_raw_ff;
   logic [COL_W+POOL_W-1:0] xs_raw_ff;
   logic [ROW_W-1:0]  ye_ff, y_ff;
   logic [COL_W-1:0]  xs_ff, xe_ff, x_ff;
   logic              pend_ff;
   logic signed [SUM_W-1:0] sum_ff;
   logic [CNT_W-1:0]  cnt_ff;
   logic              sum_neg_ff;

   // result register
   logic                rsp_valid_ff;
   logic [SAMPLE_W-1:0] avg_ff;
   logic [ROW_W-1:0]    rsp_row_ff;
   logic [COL_W-1:0]    rsp_col_ff;
   logic [CH_W-1:0]     rsp_ch_ff;
   logic                rsp_last_ff;
   logic                rsp_end_ff;

   div_req_type         div_req;
   div_rsp_type         div_rsp;
   store_wr_type        store_wr;
   logic [ADDR_W-1:0]   rd_addr;
   logic [SAMPLE_W-1:0] rd_data;

   avgp_div u_div (
      .clock (clock),
      .reset (reset),
      .req   (div_req),
      .rsp   (div_rsp)
   );

   avgp_store u_store (
      .clock   (clock),
      .wr      (store_wr),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   // clamp raw registers into their legal ranges
   logic [POOL_W-1:0] eff_pw, eff_ph, eff_sw, eff_sh;
   logic [WID_W-1:0]  eff_w;
   logic [DIM_W-1:0]  eff_h;
   logic [CHN_W-1:0]  eff_c;

   always_comb begin
      eff_pw = (cfg_pw_ff == '0) ? POOL_W'(1) :
               (cfg_pw_ff > POOL_W'(MAX_POOL)) ? POOL_W'(MAX_POOL) : cfg_pw_ff;
      eff_ph = (cfg_ph_ff == '0) ? POOL_W'(1) :
               (cfg_ph_ff > POOL_W'(MAX_POOL)) ? POOL_W'(MAX_POOL) : cfg_ph_ff;
      eff_sw = (cfg_sw_ff == '0) ? POOL_W'(1) : cfg_sw_ff;
      eff_sh = (cfg_sh_ff == '0) ? POOL_W'(1) : cfg_sh_ff;
      eff_w  = (cfg_w_ff == '0) ? WID_W'(1) :
               (cfg_w_ff > WID_W'(MAX_WIDTH)) ? WID_W'(MAX_WIDTH) : cfg_w_ff;
      eff_h  = (cfg_h_ff == '0) ? DIM_W'(1) :
               (cfg_h_ff > DIM_W'(MAX_HEIGHT)) ? DIM_W'(MAX_HEIGHT) : cfg_h_ff;
      eff_c  = (cfg_c_ff == '0) ? CHN_W'(1) :
               (cfg_c_ff > CHN_W'(MAX_CHANNELS)) ? CHN_W'(MAX_CHANNELS) : cfg_c_ff;
   end

   // select the axis being worked on: 0 columns, 1 rows
   logic [DIM_W-1:0]  ax_n, ax_outn, ax_pos;
   logic [POOL_W-1:0] ax_p, ax_s;
   logic [PAD_W-1:0]  ax_pad;

   always_comb begin
      ax_n    = axis_ff ? h_ff : DIM_W'(w_ff);
      ax_outn = axis_ff ? outh_ff : DIM_W'(outw_ff);
      ax_pos  = axis_ff ? DIM_W'(row_ff) : DIM_W'(col_ff);
      ax_p    = axis_ff ? ph_ff : pw_ff;
      ax_s    = axis_ff ? sh_ff : sw_ff;
      ax_pad  = axis_ff ? padt_ff : padl_ff;
   end

   // output size and padding of one axis
   logic [POOL_W-1:0]       p_eff;
   logic [DVD_W-1:0]        lat_dividend;
   logic [DIM_W-1:0]        lat_outn;
   logic [DIM_W+POOL_W-1:0] pad_prod;
   logic signed [TOT_W-1:0] pad_total;
   logic [PAD_W-1:0]        pad_val;

   always_comb begin
      if (!same_ff && (DIM_W'(ax_p) > ax_n)) begin
         p_eff = ax_n[POOL_W-1:0];
      end else begin
         p_eff = ax_p;
      end
      lat_dividend = DVD_W'(same_ff ? (ax_n - 1'b1) : (ax_n - DIM_W'(p_eff)));
      lat_outn     = div_rsp.quotient[DIM_W-1:0] + 1'b1;
      pad_prod     = (DIM_W+POOL_W)'(ax_outn - 1'b1) * (DIM_W+POOL_W)'(ax_s);
      pad_total    = $signed({1'b0, pad_prod}) + $signed(TOT_W'(ax_p))
                     - $signed(TOT_W'(ax_n));
      pad_val      = (same_ff && (pad_total > 0)) ? pad_total[PAD_W:1] : '0;
   end

   // output indices whose clipped window ends at the current position
   logic signed [5:0]     rng_off;
   logic signed [T_W-1:0] rng_t, rng_t_up;
   logic                  t_neg, last_pos;
   logic [DVD_W-1:0]      rng_dividend;
   logic [DIM_W-1:0]      rng_q, rng_lo, rng_hi;
   logic                  rng_empty;

   always_comb begin
      rng_off      = $signed(6'(ax_p)) - 6'sd1 - $signed(6'(ax_pad));
      rng_t        = $signed(T_W'(ax_pos)) - T_W'(rng_off);
      rng_t_up     = rng_t + $signed(T_W'(ax_s)) - T_W'(1);
      t_neg        = rng_t[T_W-1];
      last_pos     = ax_pos == (ax_n - 1'b1);
      rng_dividend = DVD_W'($unsigned(last_pos ? rng_t_up : rng_t));
      rng_q        = div_rsp.quotient[DIM_W-1:0];
      if (t_neg) begin
         rng_lo    = '0;
         rng_hi    = ax_outn - 1'b1;
         rng_empty = !last_pos;
      end else if (last_pos) begin
         rng_lo    = rng_q;
         rng_hi    = ax_outn - 1'b1;
         rng_empty = rng_q > (ax_outn - 1'b1);
      end else begin
         rng_lo    = rng_q;
         rng_hi    = rng_q;
         rng_empty = (div_rsp.remainder != '0) || (rng_q >= ax_outn);
      end
   end

   // clip the window to the frame
   logic signed [WIN_W-1:0] ys_s, ye_s, h_lim, ys_c, ye_c;
   logic signed [WIN_W-1:0] xs_s, xe_s, w_lim, xs_c, xe_c;

   always_comb begin
      ys_s  = $signed(WIN_W'(ys_raw_ff)) - $signed(WIN_W'(padt_ff));
      ye_s  = ys_s + $signed(WIN_W'(ph_ff)) - WIN_W'(1);
      h_lim = $signed(WIN_W'(h_ff)) - WIN_W'(1);
      ys_c  = (ys_s < 0) ? '0 : ys_s;
      ye_c  = (ye_s < 0) ? '0 : ((ye_s > h_lim) ? h_lim : ye_s);
      xs_s  = $signed(WIN_W'(xs_raw_ff)) - $signed(WIN_W'(padl_ff));
      xe_s  = xs_s + $signed(WIN_W'(pw_ff)) - WIN_W'(1);
      w_lim = $signed(WIN_W'(w_ff)) - WIN_W'(1);
      xs_c  = (xs_s < 0) ? '0 : xs_s;
      xe_c  = (xe_s < 0) ? '0 : ((xe_s > w_lim) ? w_lim : xe_s);
   end

   // average from the divider, sign restored
   logic [DVD_W-1:0]    sum_mag;
   logic [SAMPLE_W-1:0] avg_q;
   logic [SAMPLE_W-1:0] avg_val;
   logic                pos_zero;
   logic                res_last;
   logic                res_end;

   always_comb begin
      sum_mag  = sum_ff[SUM_W-1] ? DVD_W'($unsigned(-sum_ff)) : DVD_W'($unsigned(sum_ff));
      avg_q    = div_rsp.quotient[SAMPLE_W-1:0];
      avg_val  = sum_neg_ff ? (~avg_q + 1'b1) : avg_q;
      pos_zero = (row_ff == '0) && (col_ff == '0) && (chan_ff == '0);
      res_last = (res_cnt_ff == RES_W'(MAX_RESULTS - 1))
                 || ((ox_ff == xhi_ff) && (oy_ff == yhi_ff));
      res_end  = (DIM_W'(oy_ff) == (outh_ff - 1'b1))
                 && (WID_W'(ox_ff) == (outw_ff - 1'b1))
                 && (CHN_W'(chan_ff) == (c_ff - 1'b1));
   end

   // drive the shared divider
   always_comb begin
      div_req.start    = (state_ff == S_LAT_DIV) || (state_ff == S_AVG_DIV)
                         || ((state_ff == S_RNG_DIV) && !t_neg);
      div_req.dividend = sum_mag;
      div_req.divisor  = cnt_ff;
      case (state_ff)
         S_LAT_DIV: begin
            div_req.dividend = lat_dividend;
            div_req.divisor  = DVS_W'(ax_s);
         end
         S_RNG_DIV: begin
            div_req.dividend = rng_dividend;
            div_req.divisor  = DVS_W'(ax_s);
         end
         default: begin
            div_req.dividend = sum_mag;
            div_req.divisor  = cnt_ff;
         end
      endcase
   end

   // store the accepted sample, read window cells
   assign store_wr.en   = req_bus.valid && req_bus.ready;
   assign store_wr.addr = {row_ff[SLOT_W-1:0], col_ff, chan_ff};
   assign store_wr.data = req_bus.sample;
   assign rd_addr       = {y_ff[SLOT_W-1:0], x_ff, chan_ff};

   assign req_bus.ready     = (state_ff == S_IDLE) && !reset;
   assign rsp_bus.valid     = rsp_valid_ff;
   assign rsp_bus.average   = avg_ff;
   assign rsp_bus.out_row   = rsp_row_ff;
   assign rsp_bus.out_col   = rsp_col_ff;
   assign rsp_bus.channel   = rsp_ch_ff;
   assign rsp_bus.last      = rsp_last_ff;
   assign rsp_bus.frame_end = rsp_end_ff;

   // configuration writes
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_pw_ff   <= RST_POOL;
         cfg_ph_ff   <= RST_POOL;
         cfg_sw_ff   <= RST_STRIDE;
         cfg_sh_ff   <= RST_STRIDE;
         cfg_w_ff    <= RST_WIDTH;
         cfg_h_ff    <= RST_HEIGHT;
         cfg_c_ff    <= RST_CHANS;
         cfg_same_ff <= 1'b0;
      end else if (csr_wr_en) begin
         case (csr_index_type'(csr_index))
            CSR_POOL_WIDTH:    cfg_pw_ff   <= csr_data[POOL_W-1:0];
            CSR_POOL_HEIGHT:   cfg_ph_ff   <= csr_data[POOL_W-1:0];
            CSR_STRIDE_WIDTH:  cfg_sw_ff   <= csr_data[POOL_W-1:0];
            CSR_STRIDE_HEIGHT: cfg_sh_ff   <= csr_data[POOL_W-1:0];
            CSR_IN_WIDTH:      cfg_w_ff    <= csr_data[WID_W-1:0];
            CSR_IN_HEIGHT:     cfg_h_ff    <= csr_data[DIM_W-1:0];
            CSR_CHANNELS:      cfg_c_ff    <= csr_data[CHN_W-1:0];
            CSR_SAME_PADDING:  cfg_same_ff <= csr_data[0];
            default: ;
         endcase
      end
   end

   // sequencer and result register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
         pend_ff      <= 1'b0;
         axis_ff      <= 1'b0;
         row_ff       <= '0;
         col_ff       <= '0;
         chan_ff      <= '0;
         pw_ff        <= RST_POOL;
         ph_ff        <= RST_POOL;
         sw_ff        <= RST_STRIDE;
         sh_ff        <= RST_STRIDE;
         w_ff         <= RST_WIDTH;
         h_ff         <= RST_HEIGHT;
         c_ff         <= RST_CHANS;
         same_ff      <= 1'b0;
         outw_ff      <= RST_OUT_W;
         outh_ff      <= RST_OUT_H;
         padl_ff      <= '0;
         padt_ff      <= '0;
      end else begin
         pend_ff <= 1'b0;

         // accumulate the cell read last cycle
         if (pend_ff) begin
            sum_ff <= sum_ff + SUM_W'($signed(rd_data));
            cnt_ff <= cnt_ff + 1'b1;
         end

         case (state_ff)
            S_IDLE: begin
               if (req_bus.valid) begin
                  empty_ff   <= 1'b0;
                  axis_ff    <= 1'b0;
                  res_cnt_ff <= '0;
                  if (pos_zero) begin
                     pw_ff    <= eff_pw;
                     ph_ff    <= eff_ph;
                     sw_ff    <= eff_sw;
                     sh_ff    <= eff_sh;
                     w_ff     <= eff_w;
                     h_ff     <= eff_h;
                     c_ff     <= eff_c;
                     same_ff  <= cfg_same_ff;
                     state_ff <= S_LAT_DIV;
                  end else begin
                     state_ff <= S_RNG_DIV;
                  end
               end
            end

            // shrink the window to the frame, start the size divide
            S_LAT_DIV: begin
               if (axis_ff) begin
                  ph_ff <= p_eff;
               end else begin
                  pw_ff <= p_eff;
               end
               state_ff <= S_LAT_WAIT;
            end

            S_LAT_WAIT: begin
               if (div_rsp.done) begin
                  if (axis_ff) begin
                     outh_ff <= lat_outn;
                  end else begin
                     outw_ff <= lat_outn[WID_W-1:0];
                  end
                  state_ff <= S_LAT_PAD;
               end
            end

            S_LAT_PAD: begin
               if (axis_ff) begin
                  padt_ff  <= pad_val;
                  axis_ff  <= 1'b0;
                  state_ff <= S_RNG_DIV;
               end else begin
                  padl_ff  <= pad_val;
                  axis_ff  <= 1'b1;
                  state_ff <= S_LAT_DIV;
               end
            end

            // start the window-end divide; before the first window: resolve without a divide
            S_RNG_DIV: begin
               if (t_neg) begin
                  if (axis_ff) begin
                     ylo_ff <= rng_lo[ROW_W-1:0];
                     yhi_ff <= rng_hi[ROW_W-1:0];
                  end else begin
                     xlo_ff <= rng_lo[COL_W-1:0];
                     xhi_ff <= rng_hi[COL_W-1:0];
                  end
                  empty_ff <= empty_ff | rng_empty;
                  axis_ff  <= 1'b1;
                  state_ff <= axis_ff ? S_RNG_END : S_RNG_DIV;
               end else begin
                  state_ff <= S_RNG_WAIT;
               end
            end

            S_RNG_WAIT: begin
               if (div_rsp.done) begin
                  if (axis_ff) begin
                     ylo_ff <= rng_lo[ROW_W-1:0];
                     yhi_ff <= rng_hi[ROW_W-1:0];
                  end else begin
                     xlo_ff <= rng_lo[COL_W-1:0];
                     xhi_ff <= rng_hi[COL_W-1:0];
                  end
                  empty_ff <= empty_ff | rng_empty;
                  axis_ff  <= 1'b1;
                  state_ff <= axis_ff ? S_RNG_END : S_RNG_DIV;
               end
            end

            S_RNG_END: begin
               oy_ff    <= ylo_ff;
               ox_ff    <= xlo_ff;
               state_ff <= empty_ff ? S_FIN : S_WIN_MUL;
            end

            // window origin before padding
            S_WIN_MUL: begin
               ys_raw_ff <= (ROW_W+POOL_W)'(oy_ff) * (ROW_W+POOL_W)'(sh_ff);
               xs_raw_ff <= (COL_W+POOL_W)'(ox_ff) * (COL_W+POOL_W)'(sw_ff);
               state_ff  <= S_WIN_CLIP;
            end

            S_WIN_CLIP: begin
               ye_ff    <= ye_c[ROW_W-1:0];
               y_ff     <= ys_c[ROW_W-1:0];
               xs_ff    <= xs_c[COL_W-1:0];
               xe_ff    <= xe_c[COL_W-1:0];
               x_ff     <= xs_c[COL_W-1:0];
               sum_ff   <= '0;
               cnt_ff   <= '0;
               state_ff <= S_SUM;
            end

            // walk the window cells, one read a cycle
            S_SUM: begin
               pend_ff <= 1'b1;
               if (x_ff == xe_ff) begin
                  x_ff <= xs_ff;
                  if (y_ff == ye_ff) begin
                     state_ff <= S_SUM_TAIL;
                  end else begin
                     y_ff <= y_ff + 1'b1;
                  end
               end else begin
                  x_ff <= x_ff + 1'b1;
               end
            end

            S_SUM_TAIL: begin
               state_ff <= S_AVG_DIV;
            end

            S_AVG_DIV: begin
               sum_neg_ff <= sum_ff[SUM_W-1];
               state_ff   <= S_AVG_WAIT;
            end

            S_AVG_WAIT: begin
               if (div_rsp.done) begin
                  avg_ff       <= avg_val;
                  rsp_row_ff   <= oy_ff;
                  rsp_col_ff   <= ox_ff;
                  rsp_ch_ff    <= chan_ff;
                  rsp_last_ff  <= res_last;
                  rsp_end_ff   <= res_end;
                  rsp_valid_ff <= 1'b1;
                  state_ff     <= S_OUT;
               end
            end

            // hold the beat until taken, then step to the next window
            S_OUT: begin
               if (rsp_bus.ready) begin
                  rsp_valid_ff <= 1'b0;
                  res_cnt_ff   <= res_cnt_ff + 1'b1;
                  if (rsp_last_ff) begin
                     state_ff <= S_FIN;
                  end else begin
                     if (ox_ff == xhi_ff) begin
                        ox_ff <= xlo_ff;
                        oy_ff <= oy_ff + 1'b1;
                     end else begin
                        ox_ff <= ox_ff + 1'b1;
                     end
                     state_ff <= S_WIN_MUL;
                  end
               end
            end

            // advance the raster position
            S_FIN: begin
               if (({1'b0, chan_ff} + 1'b1) >= c_ff) begin
                  chan_ff <= '0;
                  if (({1'b0, col_ff} + 1'b1) >= w_ff) begin
                     col_ff <= '0;
                     if (({1'b0, row_ff} + 1'b1) >= h_ff) begin
                        row_ff <= '0;
                     end else begin
                        row_ff <= row_ff + 1'b1;
                     end
                  end else begin
                     col_ff <= col_ff + 1'b1;
                  end
               end else begin
                  chan_ff <= chan_ff + 1'b1;
               end
               state_ff <= S_IDLE;
            end

            default: begin
               state_ff <= S_IDLE;
            end
         endcase
      end
   end

endmodule

// ===== rtl/avgp_div.sv =====
// ----------------------------------------------------------------------------
// avgp_div: shared unsigned divider
// Restoring divider, one quotient bit per cycle; done pulses with the
// quotient and remainder valid.
// ----------------------------------------------------------------------------
module avgp_div (
   input  logic                  clock,
   input  logic                  reset,
   input  avgp_pkg::div_req_type req,
   output avgp_pkg::div_rsp_type rsp
);
   import avgp_pkg::*;

   logic              busy_ff;
   logic              done_ff;
   logic [DCNT_W-1:0] count_ff;
   logic [DVD_W-1:0]  quo_ff;
   logic [DVS_W-1:0]  rem_ff;
   logic [DVS_W-1:0]  divisor_ff;

   logic [DVS_W:0]    shifted;
   logic [DVS_W:0]    diff;
   logic              trial_bit;
   logic [DVS_W-1:0]  trial_rem;

   // trial subtract of the next partial remainder
   always_comb begin
      shifted   = {rem_ff, quo_ff[DVD_W-1]};
      diff      = shifted - {1'b0, divisor_ff};
      trial_bit = shifted >= {1'b0, divisor_ff};
      trial_rem = trial_bit ? diff[DVS_W-1:0] : shifted[DVS_W-1:0];
   end

   // load on start, then shift one bit a cycle
   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff  <= 1'b0;
         done_ff  <= 1'b0;
         count_ff <= '0;
      end else begin
         done_ff <= 1'b0;
         if (req.start) begin
            quo_ff     <= req.dividend;
            rem_ff     <= '0;
            divisor_ff <= req.divisor;
            count_ff   <= DCNT_W'(DVD_W);
            busy_ff    <= 1'b1;
         end else if (busy_ff) begin
            rem_ff   <= trial_rem;
            quo_ff   <= {quo_ff[DVD_W-2:0], trial_bit};
            count_ff <= count_ff - 1'b1;
            if (count_ff == DCNT_W'(1)) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

   assign rsp.done      = done_ff;
   assign rsp.quotient  = quo_ff;
   assign rsp.remainder = rem_ff;

endmodule

// ===== rtl/avgp_store.sv =====
// ----------------------------------------------------------------------------
// avgp_store: line store
// Holds the most recent window rows of every column and channel; one write
// port and one registered read port.
// ----------------------------------------------------------------------------
module avgp_store (
   input  logic                          clock,
   input  avgp_pkg::store_wr_type        wr,
   input  logic [avgp_pkg::ADDR_W-1:0]   rd_addr,
   output logic [avgp_pkg::SAMPLE_W-1:0] rd_data
);
   import avgp_pkg::*;

   logic [SAMPLE_W-1:0] mem [0:STORE_DEPTH-1];

   // write the new sample, read one window cell a cycle
   always_ff @(posedge clock) begin
      if (wr.en) begin
         mem[wr.addr] <= wr.data;
      end
      rd_data <= mem[rd_addr];
   end

endmodule
